FILE: rtl/dllm_pkg.sv
package dllm_pkg;

    localparam int NODES  = 64;
    localparam int IDX_W  = $clog2(NODES);
    localparam int LINK_W = 7;
    localparam int OP_W   = 3;
    localparam int A_W    = 6;

    localparam logic [LINK_W-1:0] NONE_IDX = LINK_W'(NODES);

    localparam logic [OP_W-1:0] OP_PUSH_HEAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_HEAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_TAIL   = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd4;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP        = 3'd7;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [IDX_W-1:0]  t_idx;

    function automatic logic is_node(input t_link v);
        return v < LINK_W'(NODES);
    endfunction

    function automatic t_idx to_idx(input t_link v);
        return v[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/dllm_op_if.sv
interface dllm_op_if import dllm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [A_W-1:0]    node_a;
    logic [LINK_W-1:0] node_b;

    modport source (output valid, output operation, output node_a, output node_b,
                    input ready);
    modport sink   (input valid, input operation, input node_a, input node_b,
                    output ready);
endinterface

FILE: rtl/dllm_res_if.sv
interface dllm_res_if import dllm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LINK_W-1:0] popped_node;
    logic              list_empty;

    modport source (output valid, output popped_node, output list_empty, input ready);
    modport sink   (input valid, input popped_node, input list_empty, output ready);
endinterface

FILE: rtl/doubly_linked_list_manager.sv
// Doubly linked list manager over a pool of NODES node indices.
// i_op carries one list operation per transaction (push head/tail, pop
// head/tail, insert before/after a reference node, remove a node); o_res
// returns one transaction per operation with the popped node (NODES when
// nothing was popped) and the list-empty flag after the operation.
// Both channels use valid/ready; a transaction moves when both are high.
// The block takes one operation at a time: the accept cycle issues the
// link reads, then states S_W1 and S_W2 write the links back; i_op.ready
// is high only in S_IDLE. Each link memory has a single port, and one
// operation may write two entries of one memory, so writes use both states.
// o_res.valid is raised as S_W2 completes. The result sits in an output
// register; while it is not taken the block still accepts the next
// operation and holds that one in S_W2 until the output register frees.
// Reset empties the list (head and tail to none) and drops any pending
// result; link memories are not cleared and hold stale links.
module doubly_linked_list_manager import dllm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dllm_op_if.sink    i_op,
    dllm_res_if.source o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_W1   = 2'd1;
    localparam logic [1:0] S_W2   = 2'd2;

    t_link r_prev_mem [NODES];
    t_link r_next_mem [NODES];

    logic [1:0]      r_state, n_state;
    t_link           r_head, n_head;
    t_link           r_tail, n_tail;
    logic            r_out_valid, n_out_valid;
    t_link           r_popped, n_popped;
    logic            r_empty, n_empty;
    logic [OP_W-1:0] r_op, n_op;
    t_link           r_a, r_b, r_h, r_t;
    t_link           r_rd_prev, r_rd_next;

    logic  accept, w2_go, a_ok;
    t_link in_a, in_b;
    logic  prev_re, next_re, prev_we, next_we;
    t_idx  prev_ra, next_ra, prev_wa, next_wa;
    t_link prev_wd, next_wd;

    assign accept = i_op.valid && i_op.ready;
    assign w2_go  = !r_out_valid || o_res.ready;
    assign in_a   = LINK_W'(i_op.node_a);
    assign in_b   = is_node(i_op.node_b) ? i_op.node_b : NONE_IDX;
    assign a_ok   = is_node(in_a);

    assign i_op.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.popped_node = r_popped;
    assign o_res.list_empty  = r_empty;

    always_comb begin
        n_op = i_op.operation;
        case (i_op.operation) inside
            OP_PUSH_HEAD, OP_PUSH_TAIL, OP_REMOVE: begin
                if (!a_ok) n_op = OP_NOP;
            end
            OP_INS_BEFORE: begin
                if (!a_ok) n_op = OP_NOP;
                else if (!is_node(in_b)) n_op = OP_PUSH_TAIL;
            end
            OP_INS_AFTER: begin
                if (!a_ok) n_op = OP_NOP;
                else if (!is_node(in_b)) n_op = OP_PUSH_HEAD;
            end
            default: ;
        endcase
    end

    always_comb begin
        prev_re = 1'b0;
        prev_ra = '0;
        next_re = 1'b0;
        next_ra = '0;
        if (accept) begin
            case (i_op.operation)
                OP_POP_HEAD: begin
                    next_re = is_node(r_head);
                    next_ra = to_idx(r_head);
                end
                OP_POP_TAIL: begin
                    prev_re = is_node(r_tail);
                    prev_ra = to_idx(r_tail);
                end
                OP_INS_BEFORE: begin
                    prev_re = a_ok && is_node(in_b);
                    prev_ra = to_idx(in_b);
                end
                OP_INS_AFTER: begin
                    next_re = a_ok && is_node(in_b);
                    next_ra = to_idx(in_b);
                end
                OP_REMOVE: begin
                    prev_re = a_ok;
                    prev_ra = to_idx(in_a);
                    next_re = a_ok;
                    next_ra = to_idx(in_a);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !o_res.ready;
        n_popped    = r_popped;
        n_empty     = r_empty;
        prev_we     = 1'b0;
        prev_wa     = '0;
        prev_wd     = '0;
        next_we     = 1'b0;
        next_wa     = '0;
        next_wd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_W1;
            end
            S_W1: begin
                n_state = S_W2;
                case (r_op)
                    OP_PUSH_HEAD: begin
                        prev_we = 1'b1;
                        prev_wa = to_idx(r_a);
                        prev_wd = NONE_IDX;
                        next_we = 1'b1;
                        next_wa = to_idx(r_a);
                        next_wd = r_h;
                        n_head  = r_a;
                        if (!is_node(r_h)) n_tail = r_a;
                    end
                    OP_PUSH_TAIL: begin
                        prev_we = 1'b1;
                        prev_wa = to_idx(r_a);
                        prev_wd = r_t;
                        next_we = 1'b1;
                        next_wa = to_idx(r_a);
                        next_wd = NONE_IDX;
                        n_tail  = r_a;
                        if (!is_node(r_t)) n_head = r_a;
                    end
                    OP_POP_HEAD: begin
                        if (is_node(r_h)) begin
                            n_head = r_rd_next;
                            if (!is_node(r_rd_next)) begin
                                n_tail = NONE_IDX;
                            end else begin
                                prev_we = 1'b1;
                                prev_wa = to_idx(r_rd_next);
                                prev_wd = NONE_IDX;
                            end
                        end
                    end
                    OP_POP_TAIL: begin
                        if (is_node(r_t)) begin
                            n_tail = r_rd_prev;
                            if (!is_node(r_rd_prev)) begin
                                n_head = NONE_IDX;
                            end else begin
                                next_we = 1'b1;
                                next_wa = to_idx(r_rd_prev);
                                next_wd = NONE_IDX;
                            end
                        end
                    end
                    OP_INS_BEFORE: begin
                        prev_we = 1'b1;
                        prev_wa = to_idx(r_a);
                        prev_wd = r_rd_prev;
                        next_we = 1'b1;
                        next_wa = to_idx(r_a);
                        next_wd = r_b;
                        if (!is_node(r_rd_prev)) n_head = r_a;
                    end
                    OP_INS_AFTER: begin
                        prev_we = 1'b1;
                        prev_wa = to_idx(r_a);
                        prev_wd = r_b;
                        next_we = 1'b1;
                        next_wa = to_idx(r_a);
                        next_wd = r_rd_next;
                        if (!is_node(r_rd_next)) n_tail = r_a;
                    end
                    OP_REMOVE: begin
                        if (!is_node(r_rd_prev)) begin
                            n_head = r_rd_next;
                        end else begin
                            next_we = 1'b1;
                            next_wa = to_idx(r_rd_prev);
                            next_wd = r_rd_next;
                        end
                        if (!is_node(r_rd_next)) begin
                            n_tail = r_rd_prev;
                        end else begin
                            prev_we = 1'b1;
                            prev_wa = to_idx(r_rd_next);
                            prev_wd = r_rd_prev;
                        end
                    end
                    default: ;
                endcase
            end
            S_W2: begin
                if (w2_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_empty     = !is_node(r_head) && !is_node(r_tail);
                    n_popped    = (r_op == OP_POP_HEAD) ? r_h :
                                  (r_op == OP_POP_TAIL) ? r_t : NONE_IDX;
                    case (r_op)
                        OP_PUSH_HEAD: begin
                            prev_we = is_node(r_h);
                            prev_wa = to_idx(r_h);
                            prev_wd = r_a;
                        end
                        OP_PUSH_TAIL: begin
                            next_we = is_node(r_t);
                            next_wa = to_idx(r_t);
                            next_wd = r_a;
                        end
                        OP_INS_BEFORE: begin
                            prev_we = 1'b1;
                            prev_wa = to_idx(r_b);
                            prev_wd = r_a;
                            next_we = is_node(r_rd_prev);
                            next_wa = to_idx(r_rd_prev);
                            next_wd = r_a;
                        end
                        OP_INS_AFTER: begin
                            prev_we = is_node(r_rd_next);
                            prev_wa = to_idx(r_rd_next);
                            prev_wd = r_a;
                            next_we = 1'b1;
                            next_wa = to_idx(r_b);
                            next_wd = r_a;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NONE_IDX;
            r_tail      <= NONE_IDX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_empty  <= n_empty;
        if (accept) begin
            r_op <= n_op;
            r_a  <= in_a;
            r_b  <= in_b;
            r_h  <= r_head;
            r_t  <= r_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end else if (prev_re) begin
            r_rd_prev <= r_prev_mem[prev_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end else if (next_re) begin
            r_rd_next <= r_next_mem[next_ra];
        end
    end

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(prev_we && prev_re) && !(next_we && next_re))
        else $error("link memory read and written in the same cycle");

    a_accept_to_w1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_W1))
        else $error("accepted transaction did not start the write sequence");

    a_result_after_w2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_W2))
        else $error("result raised outside the final write cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (prev_we || next_we) |-> (r_state != S_IDLE))
        else $error("link write while idle");

endmodule
